// ===== rtl/jac_pkg.sv =====
package jac_pkg;

  localparam int CNT_W = 12;
  localparam int POS_W = 16;
  localparam int QUO_W = 15;
  localparam int SPAN_W = 11;
  localparam int BTN_W = 4;
  localparam int ST_W = 8;

  // counts at or above this mean the axis timed out
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 12'd2048;
  localparam logic [SPAN_W-1:0] MIN_SPAN_RST = 11'd32;

  // one quotient bit per divider step
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  localparam logic signed [POS_W-1:0] POS_THRESH = 16'sh4000;
  localparam logic signed [POS_W-1:0] NEG_THRESH = -16'sh4000;

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

// ===== rtl/jac_axis_lane.sv =====
module jac_axis_lane
  import jac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]  raw_in,
  input  logic [SPAN_W-1:0] min_span,
  output logic [POS_W-1:0]  pos
);

  logic [CNT_W-1:0] raw_r, raw_nxt;
  logic [CNT_W-1:0] min_r, min_nxt;
  logic [CNT_W-1:0] cen_r, cen_nxt;
  logic [CNT_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;

  logic             raw_ok;
  logic [CNT_W-1:0] min_upd, cen_upd, max_upd;
  logic             below;
  logic signed [CNT_W:0] span;
  logic             span_short;
  logic [CNT_W:0]   rem_dbl;
  logic             fits;

  // calibration learning for the captured sample
  always_comb begin
    raw_ok  = raw_r < COUNT_LIMIT;
    cen_upd = (cen_r == '0) ? raw_r : cen_r;
    min_upd = (min_r == '0 || raw_r < min_r) ? raw_r : min_r;
    max_upd = (raw_r > max_r) ? raw_r : max_r;
    if (!raw_ok) begin
      cen_upd = cen_r;
      min_upd = min_r;
      max_upd = max_r;
    end
    below      = raw_r < cen_upd;
    span       = $signed({1'b0, max_upd}) - $signed({1'b0, min_upd});
    span_short = span < $signed({2'b00, min_span});
  end

  // restoring divider; for a valid count the remainder stays below the divisor
  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    fits    = rem_dbl >= {1'b0, den_r};
  end

  always_comb begin
    raw_nxt  = raw_r;
    min_nxt  = min_r;
    cen_nxt  = cen_r;
    max_nxt  = max_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (ctrl.capture) begin
      raw_nxt = raw_in;
    end
    if (ctrl.load) begin
      min_nxt  = min_upd;
      cen_nxt  = cen_upd;
      max_nxt  = max_upd;
      neg_nxt  = below;
      zero_nxt = !raw_ok || span_short;
      quo_nxt  = '0;
      if (below) begin
        rem_nxt = raw_r - min_upd;
        den_nxt = cen_upd - min_upd;
      end else begin
        rem_nxt = raw_r - cen_upd;
        den_nxt = max_upd - cen_upd + 12'd1;
      end
    end
    if (ctrl.step) begin
      if (fits) begin
        rem_nxt = CNT_W'(rem_dbl - {1'b0, den_r});
      end else begin
        rem_nxt = rem_dbl[CNT_W-1:0];
      end
      quo_nxt = {quo_r[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      cen_r <= '0;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      cen_r <= cen_nxt;
      max_r <= max_nxt;
    end
    raw_r  <= raw_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // below centre the position is quotient - 0x8000, i.e. the sign bit set on top
  assign pos = zero_r ? '0 : {neg_r, quo_r};

endmodule

// ===== rtl/jac_merge.sv =====
module jac_merge
  import jac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             emit,
  input  logic [POS_W-1:0] x_pos,
  input  logic [POS_W-1:0] y_pos,
  input  logic [BTN_W-1:0] buttons,
  output logic [POS_W-1:0] x_pos_q,
  output logic [POS_W-1:0] y_pos_q,
  output logic [ST_W-1:0]  state_q,
  output logic [ST_W-1:0]  changed_q,
  output logic [ST_W-1:0]  pressed_q
);

  logic [ST_W-1:0]  last_r, last_nxt;
  logic [POS_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [ST_W-1:0]  st_r, st_nxt, chg_r, chg_nxt, prs_r, prs_nxt;
  logic [ST_W-1:0]  cur;
  logic [ST_W-1:0]  diff;

  always_comb begin
    cur      = {buttons, 4'b0000};
    cur[0]   = $signed(x_pos) <= NEG_THRESH;
    cur[1]   = $signed(x_pos) > POS_THRESH;
    cur[2]   = $signed(y_pos) <= NEG_THRESH;
    cur[3]   = $signed(y_pos) > POS_THRESH;
    diff     = cur ^ last_r;
    last_nxt = last_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    st_nxt   = st_r;
    chg_nxt  = chg_r;
    prs_nxt  = prs_r;
    if (emit) begin
      last_nxt = cur;
      x_nxt    = x_pos;
      y_nxt    = y_pos;
      st_nxt   = cur;
      chg_nxt  = diff;
      prs_nxt  = cur & diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else begin
      last_r <= last_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    st_r  <= st_nxt;
    chg_r <= chg_nxt;
    prs_r <= prs_nxt;
  end

  assign x_pos_q   = x_r;
  assign y_pos_q   = y_r;
  assign state_q   = st_r;
  assign changed_q = chg_r;
  assign pressed_q = prs_r;

endmodule

// ===== rtl/joystick_axis_autocalibrate.sv =====
// Two-axis analog joystick front end that learns its own calibration. Each
// item is one sample: a charge-time count per axis (2048 or more = timed out)
// and four button bits. Per axis the first valid count becomes the centre and
// the min and max counts are tracked; the result is a signed Q15 position,
// scaled separately on each side of the centre, and zero on timeout or while
// the learned span is below min_span. A result is registered after its item is
// accepted by one calibration update, 15 steps of the per-axis bit-serial
// divider and one merge into the output register. The next item can be
// accepted in the cycle after that merge, not before; the previous result may
// still wait meanwhile, but a new result that finds the old one unaccepted
// holds the block until out_tready.
module joystick_axis_autocalibrate
  import jac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // x_count[11:0], y_count[23:12], button_bits[27:24], zero pad [31:28]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // x_pos[15:0], y_pos[31:16], input_state[39:32], changed_bits[47:40],
  // pressed_bits[55:48]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [SPAN_W-1:0]     cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0] min_span_r, min_span_nxt;
  logic [BTN_W-1:0]  btn_r, btn_nxt;
  lane_ctrl_t        lane_ctrl;
  logic              emit;
  logic              accept;
  logic [POS_W-1:0]  x_pos, y_pos;
  logic [POS_W-1:0]  x_q, y_q;
  logic [ST_W-1:0]   st_q, chg_q, prs_q;

  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == LAST_STEP) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready         = 1'b0;
    lane_ctrl         = '0;
    emit              = 1'b0;
    step_nxt          = step_r;
    case (state_r)
      ST_IDLE: begin
        in_tready         = 1'b1;
        lane_ctrl.capture = in_tvalid;
      end
      ST_LOAD: begin
        lane_ctrl.load = 1'b1;
        step_nxt       = '0;
      end
      ST_DIV: begin
        lane_ctrl.step = 1'b1;
        step_nxt       = step_r + 1'b1;
      end
      ST_EMIT: begin
        emit = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    min_span_nxt = (cfg_valid && cfg_ready) ? cfg_data : min_span_r;
    btn_nxt      = accept ? in_tdata[27:24] : btn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      min_span_r  <= MIN_SPAN_RST;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      min_span_r  <= min_span_nxt;
      step_r      <= step_nxt;
    end
    btn_r <= btn_nxt;
  end

  jac_axis_lane u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (lane_ctrl),
    .raw_in   (in_tdata[11:0]),
    .min_span (min_span_r),
    .pos      (x_pos)
  );

  jac_axis_lane u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (lane_ctrl),
    .raw_in   (in_tdata[23:12]),
    .min_span (min_span_r),
    .pos      (y_pos)
  );

  jac_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .buttons   (btn_r),
    .x_pos_q   (x_q),
    .y_pos_q   (y_q),
    .state_q   (st_q),
    .changed_q (chg_q),
    .pressed_q (prs_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {prs_q, chg_q, st_q, y_q, x_q};

endmodule

// ===== tb/joystick_cal_checker.sv =====
`timescale 1ns / 100ps

module joystick_cal_checker
  import jac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [SPAN_W-1:0]     cfg_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  localparam int LEFT_BIT  = 0;
  localparam int RIGHT_BIT = 1;
  localparam int UP_BIT    = 2;
  localparam int DOWN_BIT  = 3;
  localparam int X_AXIS    = 0;
  localparam int Y_AXIS    = 1;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [ST_W-1:0]         input_state;
    logic [ST_W-1:0]         changed_bits;
    logic [ST_W-1:0]         pressed_bits;
  } joy_result_t;

  // learned calibration, zero in min/centre means not learned yet
  logic [CNT_W-1:0]  cal_min[2];
  logic [CNT_W-1:0]  cal_centre[2];
  logic [CNT_W-1:0]  cal_max[2];
  logic [SPAN_W-1:0] span_floor;
  logic [ST_W-1:0]   prev_state;

  joy_result_t       joy_results_q[$];
  joy_result_t       want;
  joy_result_t       got;

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    $display("checker: result %0d %s got %0d, wanted %0d", checked, what, seen, wanted);
    fail_count++;
  endtask

  function automatic logic signed [POS_W-1:0] axis_position(input int a,
                                                            input logic [CNT_W-1:0] raw);
    int          pos;
    int unsigned num;
    int unsigned den;
    pos = 0;
    if (raw < COUNT_LIMIT) begin
      if (cal_centre[a] == '0) cal_centre[a] = raw;
      if (cal_min[a] == '0 || raw < cal_min[a]) cal_min[a] = raw;
      if (raw > cal_max[a]) cal_max[a] = raw;
      if (raw < cal_centre[a]) begin
        den = 32'(cal_centre[a]) - 32'(cal_min[a]);
        num = (32'(raw) - 32'(cal_min[a])) << 15;
        if (den != 0) pos = int'(num / den) - 32768;
      end else begin
        den = 32'(cal_max[a]) - 32'(cal_centre[a]) + 1;
        num = (32'(raw) - 32'(cal_centre[a])) << 15;
        if (den != 0) pos = int'(num / den);
      end
    end
    // short span suppresses movement, also while timed out
    if (int'(cal_max[a]) - int'(cal_min[a]) < int'(span_floor)) pos = 0;
    if (pos > 32767) pos = 32767;
    if (pos < -32768) pos = -32768;
    return POS_W'(pos);
  endfunction

  function automatic joy_result_t predict_sample(input logic [IN_DATA_W-1:0] d);
    joy_result_t r;
    logic [ST_W-1:0] st;
    st = {d[2*CNT_W+BTN_W-1:2*CNT_W], 4'b0000};
    r.x_pos = axis_position(X_AXIS, d[CNT_W-1:0]);
    r.y_pos = axis_position(Y_AXIS, d[2*CNT_W-1:CNT_W]);
    if (r.x_pos <= NEG_THRESH) st[LEFT_BIT] = 1'b1;
    else if (r.x_pos > POS_THRESH) st[RIGHT_BIT] = 1'b1;
    if (r.y_pos <= NEG_THRESH) st[UP_BIT] = 1'b1;
    else if (r.y_pos > POS_THRESH) st[DOWN_BIT] = 1'b1;
    r.input_state  = st;
    r.changed_bits = st ^ prev_state;
    r.pressed_bits = st & r.changed_bits;
    prev_state     = st;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        cal_min[a]    = '0;
        cal_centre[a] = '0;
        cal_max[a]    = '0;
      end
      span_floor = MIN_SPAN_RST;
      prev_state = '0;
      joy_results_q.delete();
      fail_count = 0;
      checked    = 0;
      pending    = 0;
    end else begin
      if (cfg_valid && cfg_ready) span_floor = cfg_data;
      if (in_tvalid && in_tready) joy_results_q.push_back(predict_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        got.x_pos        = out_tdata[POS_W-1:0];
        got.y_pos        = out_tdata[2*POS_W-1:POS_W];
        got.input_state  = out_tdata[2*POS_W+ST_W-1:2*POS_W];
        got.changed_bits = out_tdata[2*POS_W+2*ST_W-1:2*POS_W+ST_W];
        got.pressed_bits = out_tdata[2*POS_W+3*ST_W-1:2*POS_W+2*ST_W];
        if (joy_results_q.size() == 0) begin
          report_mismatch("with nothing outstanding, x_pos", got.x_pos, 0);
        end else begin
          want = joy_results_q.pop_front();
          if (got.x_pos != want.x_pos) report_mismatch("x_pos", got.x_pos, want.x_pos);
          if (got.y_pos != want.y_pos) report_mismatch("y_pos", got.y_pos, want.y_pos);
          if (got.input_state != want.input_state)
            report_mismatch("input_state", got.input_state, want.input_state);
          if (got.changed_bits != want.changed_bits)
            report_mismatch("changed_bits", got.changed_bits, want.changed_bits);
          if (got.pressed_bits != want.pressed_bits)
            report_mismatch("pressed_bits", got.pressed_bits, want.pressed_bits);
        end
        checked++;
      end
      pending = joy_results_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import jac_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 242;
  localparam int DRAIN       = 40;
  localparam int SPAN_RANDOM = -1;

  logic                  clk;
  logic                  rst_n;
  // x_count[11:0], y_count[23:12], button_bits[27:24], zero pad [31:28]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // x_pos[15:0], y_pos[31:16], input_state[39:32], changed_bits[47:40],
  // pressed_bits[55:48]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SPAN_W-1:0]     cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int stall_left;
  bit calm;

  int span_plan[PHASES] = '{0, 2047, SPAN_RANDOM, 1, 32, SPAN_RANDOM};

  logic [CNT_W-1:0] px;
  logic [CNT_W-1:0] py;
  logic [BTN_W-1:0] pb;

  joystick_axis_autocalibrate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  joystick_cal_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (calm || $urandom_range(0, 7) != 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end
  end

  task automatic push_sample(input logic [CNT_W-1:0] x, input logic [CNT_W-1:0] y,
                             input logic [BTN_W-1:0] b);
    @(negedge clk);
    in_tdata  <= IN_DATA_W'({b, y, x});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // only once everything in flight has come out
  task automatic write_span(input logic [SPAN_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CNT_W-1:0] pick_count(input logic [CNT_W-1:0] prev);
    int mode;
    int v;
    mode = $urandom_range(0, 99);
    if (mode < 8) return CNT_W'($urandom_range(2048, 4095));
    if (mode < 11) return '0;
    if (mode < 14) return ($urandom_range(0, 1) != 0) ? 12'd2047 : 12'd2048;
    if (mode < 55) begin
      v = int'(prev) + $urandom_range(0, 128) - 64;
      if (v < 1) v = 1;
      if (v > 2047) v = 2047;
      return CNT_W'(v);
    end
    return CNT_W'($urandom_range(1, 2047));
  endfunction

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tdata   = '0;
    in_tvalid  = 1'b0;
    cfg_data   = '0;
    cfg_valid  = 1'b0;
    out_tready = 1'b0;
    stall_left = 0;
    calm       = 1'b0;
    sent       = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero marker, timeouts, short span, both sides, thresholds
    push_sample(12'd0,    12'd2048, 4'h0);
    push_sample(12'd1000, 12'd4095, 4'hF);
    push_sample(12'd1010, 12'd1000, 4'h1);
    push_sample(12'd500,  12'd1500, 4'h2);
    push_sample(12'd750,  12'd750,  4'h4);   // x exactly on the left threshold
    push_sample(12'd1511, 12'd1100, 4'h8);
    push_sample(12'd1256, 12'd1000, 4'h8);   // x exactly on the right threshold
    push_sample(12'd1257, 12'd1250, 4'h0);
    push_sample(12'd2047, 12'd2047, 4'hA);
    push_sample(12'd0,    12'd0,    4'h5);
    push_sample(12'd1,    12'd2049, 4'h5);   // min of zero gets replaced
    push_sample(12'd4095, 12'd3000, 4'hF);
    push_sample(12'd1000, 12'd1000, 4'hF);
    push_sample(12'd1000, 12'd1000, 4'hF);
    push_sample(12'hAAA,  12'h555,  4'h3);
    push_sample(12'h555,  12'hAAA,  4'hC);
    push_sample(12'd2048, 12'd2048, 4'h0);

    px = 12'd1000;
    py = 12'd1000;
    pb = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (span_plan[ph] == SPAN_RANDOM) write_span(SPAN_W'($urandom_range(2, 2046)));
      else write_span(SPAN_W'(span_plan[ph]));
      calm = (ph == PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph != PHASES - 1 && $urandom_range(0, 39) == 0) calm = !calm;
        if (!calm && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 6));
        px = pick_count(px);
        py = pick_count(py);
        if ($urandom_range(0, 9) < 3) pb = BTN_W'($urandom_range(0, 15));
        push_sample(px, py, pb);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);

    $display("tb: %0d samples sent, %0d results checked, %0d mismatches",
             sent, checked, fail_count);
    $display("tb: min_span stepped through 0, 1, 32, 2047 and random values");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jac_pkg.sv
rtl/jac_axis_lane.sv
rtl/jac_merge.sv
rtl/joystick_axis_autocalibrate.sv
tb/joystick_cal_checker.sv
tb/tb.sv
